// ===== hdl/checksummed_command_frame_receiver_defines.svh =====
// Assertion macros for the checksummed command frame receiver.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef CHECKSUMMED_COMMAND_FRAME_RECEIVER_DEFINES_SVH
`define CHECKSUMMED_COMMAND_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CCFR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define CCFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ccfr_pkg.sv =====
// Shared constants for the checksummed command frame receiver.
// No dependencies; used by the top level and the testbench.
`timescale 1ns / 1ps

package ccfr_pkg;

  localparam logic [7:0] HDR_FIRST   = 8'hAA;
  localparam logic [7:0] HDR_SECOND  = 8'hAF;
  localparam logic [7:0] FUNC_LIMIT  = 8'hF1;
  localparam logic [7:0] LEN_LIMIT   = 8'd50;
  localparam logic [7:0] ACK_ID      = 8'hEF;
  localparam logic [7:0] ACK_LEN     = 8'h02;
  localparam logic [7:0] FUNC_RDREQ  = 8'h02;
  localparam logic [7:0] RDREQ_FLAG  = 8'h01;
  localparam logic [7:0] FUNC_GAIN0  = 8'h10;
  localparam logic [7:0] FUNC_GAIN1  = 8'h11;
  localparam logic [7:0] FUNC_ACK_HI = 8'h15;

  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam logic [ADDR_W-1:0] PAYLOAD_BASE = ADDR_W'(4);

  localparam logic [3:0] LAST_SLOT = 4'd8;
  localparam logic [2:0] ACK_LAST  = 3'd6;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_GAIN  = 2'd1;
  localparam logic [1:0] KIND_RDREQ = 2'd2;

endpackage

// ===== hdl/ccfr_rx_if.sv =====
// Receive byte channel: valid/ready handshake carrying one serial byte.
// No dependencies.
`timescale 1ns / 1ps

interface ccfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== hdl/ccfr_res_if.sv =====
// Result channel: valid/ready handshake carrying one parser result.
// No dependencies.
`timescale 1ns / 1ps

interface ccfr_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [7:0]         tx_byte;
  logic               gain_set;
  logic [3:0]         gain_slot;
  logic signed [15:0] gain_value;
  logic               last;

  modport source (output valid, output kind, output tx_byte, output gain_set,
                  output gain_slot, output gain_value, output last, input ready);
  modport sink   (input valid, input kind, input tx_byte, input gain_set,
                  input gain_slot, input gain_value, input last, output ready);
endinterface

// ===== hdl/checksummed_command_frame_receiver.sv =====
// Checksummed command frame receiver: frame parser, 64-byte frame store, result sequencer.
// Depends on ccfr_pkg, ccfr_rx_if, ccfr_res_if and the assertion macro header.
//
//  channel | dir | payload                                          | transfer when
//  rx      | in  | rx_byte                                          | valid && ready
//  res     | out | kind tx_byte gain_set gain_slot gain_value last  | valid && ready
//
// A byte ending no good frame sends the parser to idle; rx is ready every cycle while parsing.
// A good gain frame reads the store before each gain write (E_READ, then E_GAIN), then sends
// the acknowledge bytes; acknowledge-only frames send the acknowledge bytes alone.
// rx is held off while results drain; res stalls hold the sequencer in place.
// Reset is synchronous; store valid bits clear at once, so no clearing pass.
`timescale 1ns / 1ps
`include "checksummed_command_frame_receiver_defines.svh"

module checksummed_command_frame_receiver (
  input logic clk,
  input logic rst,
  ccfr_rx_if.sink    rx,
  ccfr_res_if.source res
);
  import ccfr_pkg::*;

  typedef enum logic [3:0] {
    P_IDLE, P_HDR, P_FUNC, P_LEN, P_PAY, P_SUM,
    E_READ, E_GAIN, E_ACK, E_RDREQ
  } state_t;

  state_t            state;
  logic [5:0]        bytes_left;
  logic [5:0]        payload_count;
  logic [7:0]        run_sum;
  logic [7:0]        func;
  logic [7:0]        first_byte;
  logic [7:0]        ack_sum;
  logic [3:0]        slot;
  logic [2:0]        ack_idx;

  logic [7:0]        store [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] store_vld;
  logic [7:0]        rd_hi;
  logic [7:0]        rd_lo;
  logic              rd_hi_vld;
  logic              rd_lo_vld;

  logic              rx_xfer;
  logic              res_xfer;
  logic              mem_we;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr_hi;
  logic [ADDR_W-1:0] rd_addr_lo;
  logic [7:0]        b;
  logic [7:0]        ack_cs;
  logic [7:0]        ack_byte;

  assign b        = rx.rx_byte;
  assign rx.ready = (state == P_IDLE) || (state == P_HDR) || (state == P_FUNC) ||
                    (state == P_LEN) || (state == P_PAY) || (state == P_SUM);
  assign rx_xfer  = rx.valid && rx.ready;
  assign res.valid = (state == E_GAIN) || (state == E_ACK) || (state == E_RDREQ);
  assign res_xfer = res.valid && res.ready;

  // payload and sum bytes go to the store; header bytes live in registers
  assign mem_we  = rx_xfer && ((state == P_SUM) || ((state == P_PAY) && (bytes_left != 6'd0)));
  assign wr_addr = PAYLOAD_BASE + payload_count;

  assign rd_addr_hi = PAYLOAD_BASE + {1'b0, slot, 1'b0};
  assign rd_addr_lo = PAYLOAD_BASE + {1'b0, slot, 1'b1};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[wr_addr] <= b;
    end
    rd_hi <= store[rd_addr_hi];
    rd_lo <= store[rd_addr_lo];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      store_vld <= '0;
      rd_hi_vld <= 1'b0;
      rd_lo_vld <= 1'b0;
    end else begin
      if (mem_we) begin
        store_vld[wr_addr] <= 1'b1;
      end
      rd_hi_vld <= store_vld[rd_addr_hi];
      rd_lo_vld <= store_vld[rd_addr_lo];
    end
  end

  always_comb begin
    ack_cs = HDR_FIRST + HDR_FIRST + ACK_ID + ACK_LEN + func + ack_sum;
    unique case (ack_idx)
      3'd0:    ack_byte = HDR_FIRST;
      3'd1:    ack_byte = HDR_FIRST;
      3'd2:    ack_byte = ACK_ID;
      3'd3:    ack_byte = ACK_LEN;
      3'd4:    ack_byte = func;
      3'd5:    ack_byte = ack_sum;
      3'd6:    ack_byte = ack_cs;
      default: ack_byte = 8'h00;
    endcase
  end

  always_comb begin
    res.kind       = KIND_ACK;
    res.tx_byte    = 8'h00;
    res.gain_set   = 1'b0;
    res.gain_slot  = 4'd0;
    res.gain_value = 16'sd0;
    res.last       = 1'b0;
    unique case (state)
      E_GAIN: begin
        res.kind       = KIND_GAIN;
        res.gain_set   = (func == FUNC_GAIN1);
        res.gain_slot  = slot;
        res.gain_value = {(rd_hi_vld ? rd_hi : 8'h00), (rd_lo_vld ? rd_lo : 8'h00)};
      end
      E_ACK: begin
        res.kind    = KIND_ACK;
        res.tx_byte = ack_byte;
        res.last    = (ack_idx == ACK_LAST);
      end
      E_RDREQ: begin
        res.kind = KIND_RDREQ;
        res.last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= P_IDLE;
      bytes_left    <= 6'd0;
      payload_count <= 6'd0;
      run_sum       <= 8'h00;
      func          <= 8'h00;
      first_byte    <= 8'h00;
      ack_sum       <= 8'h00;
      slot          <= 4'd0;
      ack_idx       <= 3'd0;
    end else begin
      unique case (state)
        P_IDLE: if (rx_xfer) begin
          if (b == HDR_FIRST) begin
            state   <= P_HDR;
            run_sum <= b;
          end
        end
        P_HDR: if (rx_xfer) begin
          state   <= (b == HDR_SECOND) ? P_FUNC : P_IDLE;
          run_sum <= run_sum + b;
        end
        P_FUNC: if (rx_xfer) begin
          state   <= (b < FUNC_LIMIT) ? P_LEN : P_IDLE;
          func    <= b;
          run_sum <= run_sum + b;
        end
        P_LEN: if (rx_xfer) begin
          if (b < LEN_LIMIT) begin
            state         <= P_PAY;
            bytes_left    <= b[5:0];
            payload_count <= 6'd0;
            run_sum       <= run_sum + b;
          end else begin
            state <= P_IDLE;
          end
        end
        P_PAY: if (rx_xfer) begin
          if (bytes_left != 6'd0) begin
            bytes_left    <= bytes_left - 6'd1;
            payload_count <= payload_count + 6'd1;
            run_sum       <= run_sum + b;
            if (payload_count == 6'd0) begin
              first_byte <= b;
            end
            if (bytes_left == 6'd1) begin
              state <= P_SUM;
            end
          end else begin
            state <= P_IDLE;  // zero length frame
          end
        end
        P_SUM: if (rx_xfer) begin
          ack_sum <= run_sum;
          slot    <= 4'd0;
          ack_idx <= 3'd0;
          state   <= P_IDLE;
          if (run_sum == b) begin
            priority if (func == FUNC_RDREQ) begin
              if (first_byte == RDREQ_FLAG) begin
                state <= E_RDREQ;
              end
            end else if ((func == FUNC_GAIN0) || (func == FUNC_GAIN1)) begin
              state <= E_READ;
            end else if ((func >= FUNC_GAIN0) && (func <= FUNC_ACK_HI)) begin
              state <= E_ACK;
            end
          end
        end
        E_READ: begin
          state <= E_GAIN;  // store read in flight for this slot
        end
        E_GAIN: if (res_xfer) begin
          if (slot == LAST_SLOT) begin
            state <= E_ACK;
          end else begin
            slot  <= slot + 4'd1;
            state <= E_READ;
          end
        end
        E_ACK: if (res_xfer) begin
          if (ack_idx == ACK_LAST) begin
            state <= P_IDLE;
          end else begin
            ack_idx <= ack_idx + 3'd1;
          end
        end
        E_RDREQ: if (res_xfer) begin
          state <= P_IDLE;
        end
        default: state <= P_IDLE;
      endcase
    end
  end

  `CCFR_ASSERT_NOW(a_no_rx_while_draining, clk, rst, res.valid, !rx.ready, "rx ready during result drain")
  `CCFR_ASSERT_NOW(a_gain_slot_range, clk, rst, state == E_GAIN, slot <= LAST_SLOT, "gain slot out of range")
  `CCFR_ASSERT_NOW(a_rdreq_func, clk, rst, state == E_RDREQ, func == FUNC_RDREQ, "read request without its function")
  `CCFR_ASSERT_NEXT(a_last_gain_to_ack, clk, rst, res_xfer && (state == E_GAIN) && (slot == LAST_SLOT), (state == E_ACK) && (ack_idx == 3'd0), "acknowledge does not follow gains")

endmodule

// ===== verif/tb.sv =====
// Testbench for the checksummed command frame receiver: directed frames, then random traffic.
// Depends on ccfr_pkg, ccfr_rx_if, ccfr_res_if and the receiver top level.
`timescale 1ns / 1ps

module tb;
  import ccfr_pkg::*;

  localparam int RANDOM_BYTES  = 144;
  localparam int DRAIN_CYCLES  = 60;
  localparam int CYCLE_LIMIT   = 200000;

  typedef enum logic [2:0] {
    PH_IDLE, PH_HDR1, PH_HDR2, PH_FUNC, PH_PAYLOAD, PH_SUM
  } parse_phase_t;

  // how the rows of the directed part are checked
  typedef enum logic [1:0] {BY_PREDICTOR, NO_RESULT, READ_REQUEST} row_check_t;

  typedef struct packed {
    logic [7:0] data;
    row_check_t chk;
  } stim_row_t;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic        gain_set;
    logic [3:0]  gain_slot;
    logic [15:0] gain_value;
    logic        last;
  } frame_result_t;

  logic clk;
  logic rst;

  ccfr_rx_if  rx_ch();
  ccfr_res_if res_ch();

  checksummed_command_frame_receiver dut (
    .clk(clk),
    .rst(rst),
    .rx (rx_ch),
    .res(res_ch)
  );

  // parser copy kept by the testbench
  parse_phase_t prs_phase;
  logic [5:0]   prs_left;
  logic [5:0]   prs_count;
  logic [7:0]   frame_mem [64];

  frame_result_t step_results[$];
  frame_result_t expected_results[$];

  int fail_count;
  int bytes_sent;
  int frame_bytes_sent;
  int results_predicted;
  int gain_writes;
  int ack_bytes;
  int rd_requests;
  int cycle_count;
  int src_idle_pct;
  int snk_stall_pct;

  // header noise, a dropped byte after zero length, read request, short gain frame,
  // bad sum
  stim_row_t directed_rows [26] = '{
    '{8'hAA, NO_RESULT}, '{8'hAA, NO_RESULT}, '{8'hAF, NO_RESULT},
    '{8'hAA, BY_PREDICTOR}, '{8'hAF, BY_PREDICTOR}, '{8'hF0, BY_PREDICTOR},
    '{8'h00, NO_RESULT}, '{8'hAA, NO_RESULT},
    '{8'hAA, NO_RESULT}, '{8'hAF, NO_RESULT}, '{8'h02, NO_RESULT},
    '{8'h01, NO_RESULT}, '{8'h01, NO_RESULT}, '{8'h5D, READ_REQUEST},
    '{8'hAA, BY_PREDICTOR}, '{8'hAF, BY_PREDICTOR}, '{8'h11, BY_PREDICTOR},
    '{8'h01, BY_PREDICTOR}, '{8'hFF, BY_PREDICTOR}, '{8'h6A, BY_PREDICTOR},
    '{8'hAA, NO_RESULT}, '{8'hAF, NO_RESULT}, '{8'h10, NO_RESULT},
    '{8'h01, NO_RESULT}, '{8'h00, NO_RESULT}, '{8'h00, NO_RESULT}
  };

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic frame_result_t make_result(logic [1:0] kind, logic [7:0] tx,
                                                logic set, logic [3:0] slot,
                                                logic [15:0] value, logic fin);
    frame_result_t r;
    r.kind       = kind;
    r.tx_byte    = tx;
    r.gain_set   = set;
    r.gain_slot  = slot;
    r.gain_value = value;
    r.last       = fin;
    return r;
  endfunction

  // sum check and result burst at the sum byte
  function automatic void close_frame();
    logic [5:0] total;
    logic [7:0] sum;
    logic [7:0] fn;
    logic [7:0] cks;
    logic [7:0] ack [7];
    total = prs_count + PAYLOAD_BASE;
    fn    = frame_mem[2];
    sum   = 8'h00;
    for (int i = 0; i < int'(total); i++) sum += frame_mem[i];
    if (sum != frame_mem[total]) return;
    if (fn == FUNC_RDREQ) begin
      if (frame_mem[PAYLOAD_BASE] == RDREQ_FLAG)
        step_results.push_back(make_result(KIND_RDREQ, 8'h00, 1'b0, 4'd0, 16'd0, 1'b1));
      return;
    end
    // gains come from fixed offsets whatever the length, so stale bytes show up
    if (fn == FUNC_GAIN0 || fn == FUNC_GAIN1) begin
      for (int s = 0; s <= int'(LAST_SLOT); s++)
        step_results.push_back(make_result(KIND_GAIN, 8'h00, fn == FUNC_GAIN1, 4'(s),
          {frame_mem[int'(PAYLOAD_BASE) + 2 * s], frame_mem[int'(PAYLOAD_BASE) + 2 * s + 1]},
          1'b0));
    end
    if (fn >= FUNC_GAIN0 && fn <= FUNC_ACK_HI) begin
      ack = '{HDR_FIRST, HDR_FIRST, ACK_ID, ACK_LEN, fn, sum, 8'h00};
      cks = 8'h00;
      for (int k = 0; k < int'(ACK_LAST); k++) cks += ack[k];
      ack[ACK_LAST] = cks;
      for (int k = 0; k <= int'(ACK_LAST); k++)
        step_results.push_back(make_result(KIND_ACK, ack[k], 1'b0, 4'd0, 16'd0,
                                           k == int'(ACK_LAST)));
    end
  endfunction

  function automatic void predict_byte(logic [7:0] b);
    step_results.delete();
    if (prs_phase == PH_IDLE && b == HDR_FIRST) begin
      prs_phase    = PH_HDR1;
      frame_mem[0] = b;
    end else if (prs_phase == PH_HDR1 && b == HDR_SECOND) begin
      prs_phase    = PH_HDR2;
      frame_mem[1] = b;
    end else if (prs_phase == PH_HDR2 && b < FUNC_LIMIT) begin
      prs_phase    = PH_FUNC;
      frame_mem[2] = b;
    end else if (prs_phase == PH_FUNC && b < LEN_LIMIT) begin
      // a zero length still enters the payload phase; the next byte is dropped
      prs_phase    = PH_PAYLOAD;
      frame_mem[3] = b;
      prs_left     = b[5:0];
      prs_count    = 6'd0;
    end else if (prs_phase == PH_PAYLOAD && prs_left != 6'd0) begin
      prs_left = prs_left - 6'd1;
      frame_mem[prs_count + PAYLOAD_BASE] = b;
      prs_count = prs_count + 6'd1;
      if (prs_left == 6'd0) prs_phase = PH_SUM;
    end else if (prs_phase == PH_SUM) begin
      prs_phase = PH_IDLE;
      frame_mem[prs_count + PAYLOAD_BASE] = b;
      close_frame();
    end else begin
      // unfitting byte: back to idle, not retried as a header
      prs_phase = PH_IDLE;
    end
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void check_result();
    frame_result_t want;
    if (expected_results.size() == 0) begin
      $error("result with nothing pending: kind %0d tx_byte %0h", res_ch.kind, res_ch.tx_byte);
      fail_count++;
    end else begin
      want = expected_results.pop_front();
      check_field("kind", 16'(want.kind), 16'(res_ch.kind));
      check_field("tx_byte", 16'(want.tx_byte), 16'(res_ch.tx_byte));
      check_field("gain_set", 16'(want.gain_set), 16'(res_ch.gain_set));
      check_field("gain_slot", 16'(want.gain_slot), 16'(res_ch.gain_slot));
      check_field("gain_value", want.gain_value, res_ch.gain_value);
      check_field("last", 16'(want.last), 16'(res_ch.last));
    end
    case (res_ch.kind)
      KIND_GAIN:  gain_writes++;
      KIND_RDREQ: rd_requests++;
      default:    ack_bytes++;
    endcase
  endfunction

  function automatic logic [7:0] pick_payload_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h7F;
      3:       return 8'h80;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // valid stays high across back-to-back transfers
  task automatic send_rx(logic [7:0] b, row_check_t chk);
    while ($urandom_range(99) < src_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    bytes_sent++;
    predict_byte(b);
    case (chk)
      BY_PREDICTOR: begin
        foreach (step_results[i]) expected_results.push_back(step_results[i]);
        results_predicted += step_results.size();
      end
      READ_REQUEST: begin
        expected_results.push_back(make_result(KIND_RDREQ, 8'h00, 1'b0, 4'd0, 16'd0, 1'b1));
        results_predicted++;
      end
      default: ;
    endcase
  endtask

  task automatic send_random_frame();
    logic [7:0] frame_bytes[$];
    logic [7:0] fn;
    logic [7:0] len;
    logic [7:0] sum;
    int unsigned flavor;
    flavor = $urandom_range(99);
    if (flavor < 8) begin
      // line noise between frames
      repeat ($urandom_range(1, 3)) send_rx(pick_payload_byte(), BY_PREDICTOR);
      return;
    end
    case ($urandom_range(9))
      0, 1:    fn = FUNC_RDREQ;
      2, 3:    fn = FUNC_GAIN0;
      4, 5:    fn = FUNC_GAIN1;
      6, 7:    fn = 8'($urandom_range(FUNC_GAIN1 + 1, FUNC_ACK_HI));
      8:       fn = $urandom_range(1) ? FUNC_LIMIT - 8'd1 : 8'h00;
      default: fn = 8'($urandom_range(FUNC_LIMIT - 1));
    endcase
    case ($urandom_range(15))
      0:       len = 8'h00;
      1:       len = LEN_LIMIT - 8'd1;
      2, 3:    len = 8'($urandom_range(23, LEN_LIMIT - 1));
      default: len = 8'($urandom_range(1, 22));
    endcase
    frame_bytes = '{HDR_FIRST, HDR_SECOND, fn, len};
    for (int i = 0; i < int'(len); i++)
      frame_bytes.push_back((i == 0 && fn == FUNC_RDREQ && $urandom_range(3) != 0) ?
                            RDREQ_FLAG : pick_payload_byte());
    sum = 8'h00;
    foreach (frame_bytes[i]) sum += frame_bytes[i];
    if ($urandom_range(9) == 0) sum += 8'($urandom_range(1, 255));
    frame_bytes.push_back(sum);
    if (flavor >= 88) begin
      case ($urandom_range(3))
        0:       frame_bytes[1] = HDR_SECOND ^ 8'($urandom_range(1, 255));
        1:       frame_bytes[2] = 8'($urandom_range(FUNC_LIMIT, 255));
        2:       frame_bytes[3] = 8'($urandom_range(LEN_LIMIT, 255));
        default: repeat ($urandom_range(1, frame_bytes.size() - 1)) void'(frame_bytes.pop_back());
      endcase
    end
    foreach (frame_bytes[i]) send_rx(frame_bytes[i], BY_PREDICTOR);
    frame_bytes_sent += frame_bytes.size();
  endtask

  // result side: check each transfer, then pick the next ready
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) check_result();
    res_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst            <= 1'b1;
    rx_ch.valid    <= 1'b0;
    rx_ch.rx_byte  <= 8'h00;
    fail_count        = 0;
    bytes_sent        = 0;
    frame_bytes_sent  = 0;
    results_predicted = 0;
    gain_writes       = 0;
    ack_bytes         = 0;
    rd_requests       = 0;
    src_idle_pct      = 30;
    snk_stall_pct     = 53;
    prs_phase         = PH_IDLE;
    prs_left          = 6'd0;
    prs_count         = 6'd0;
    foreach (frame_mem[i]) frame_mem[i] = 8'h00;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) send_rx(directed_rows[i].data, directed_rows[i].chk);

    results_predicted = 0;
    while (frame_bytes_sent < RANDOM_BYTES) begin
      if (frame_bytes_sent < RANDOM_BYTES / 3) begin
        src_idle_pct  = 30;
        snk_stall_pct = 53;
      end else if (frame_bytes_sent < 2 * RANDOM_BYTES / 3) begin
        src_idle_pct  = 53;
        snk_stall_pct = 30;
      end else begin
        src_idle_pct  = 0;
        snk_stall_pct = 0;
      end
      send_random_frame();
    end
    rx_ch.valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes, %0d in random frames predicting %0d results, three idle mixes.",
             bytes_sent, frame_bytes_sent, results_predicted);
    $display("Checked %0d gain writes, %0d acknowledge bytes, %0d read requests.",
             gain_writes, ack_bytes, rd_requests);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/ccfr_pkg.sv
hdl/ccfr_rx_if.sv
hdl/ccfr_res_if.sv
hdl/checksummed_command_frame_receiver.sv
verif/tb.sv
